/* rtl/setx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_pkg
// Shared types and constants for the sprite entry tile expander.
// ----------------------------------------------------------------------------
package setx_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CoordW = 17;
  localparam int unsigned PrioW  = 2;
  localparam int unsigned SizeW  = 2;
  localparam int unsigned NibW   = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned OfsW   = 6;
  localparam int unsigned PalW   = 8;

  localparam int unsigned AttrFlipXBit  = 0;
  localparam int unsigned AttrFlipYBit  = 1;
  localparam int unsigned AttrEnableBit = 2;
  localparam int unsigned AttrPrioLo    = 4;
  localparam int unsigned ColorSizeLo   = 0;
  localparam int unsigned ColorNibLo    = 4;

  localparam logic [PalW-1:0] PalBase = 8'h80;

  // Sprite descriptor handed from the front end to the expander.
  typedef struct packed {
    logic [WordW-1:0] code;
    logic [NibW-1:0]  color;
    logic             flip_x;
    logic             flip_y;
    logic [SizeW-1:0] size;
    logic [WordW-1:0] pos_y;
    logic [WordW-1:0] pos_x;
  } desc_t;

  // Highest tile index along one side: side - 1.
  function automatic logic [IdxW-1:0] side_max(input logic [SizeW-1:0] size);
    logic [IdxW-1:0] m;
    case (size)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  // Interleave column (even bits) and row (odd bits).
  function automatic logic [OfsW-1:0] layout_ofs(input logic [IdxW-1:0] col,
                                                 input logic [IdxW-1:0] row);
    return {row[2], col[2], row[1], col[1], row[0], col[0]};
  endfunction

endpackage

/* rtl/setx_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_front
// Accepts sprite entries, checks enable and pass priority, and pushes a
// descriptor for each sprite to be drawn.
// ----------------------------------------------------------------------------
module setx_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [setx_pkg::PrioW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [setx_pkg::WordW-1:0]    attr_word_i,
  input  logic [setx_pkg::WordW-1:0]    code_word_i,
  input  logic [setx_pkg::WordW-1:0]    color_word_i,
  input  logic [setx_pkg::WordW-1:0]    pos_y_i,
  input  logic [setx_pkg::WordW-1:0]    pos_x_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output setx_pkg::desc_t               q_desc_o
);

  logic [setx_pkg::PrioW-1:0] pass_prio_q;
  logic                       draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_prio_q <= '0;
    end else if (cfg_we_i) begin
      pass_prio_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    draw = attr_word_i[setx_pkg::AttrEnableBit] &&
           (attr_word_i[setx_pkg::AttrPrioLo +: setx_pkg::PrioW] == pass_prio_q);

    q_desc_o.code   = code_word_i;
    q_desc_o.color  = color_word_i[setx_pkg::ColorNibLo +: setx_pkg::NibW];
    q_desc_o.flip_x = attr_word_i[setx_pkg::AttrFlipXBit];
    q_desc_o.flip_y = attr_word_i[setx_pkg::AttrFlipYBit];
    q_desc_o.size   = color_word_i[setx_pkg::ColorSizeLo +: setx_pkg::SizeW];
    q_desc_o.pos_y  = pos_y_i;
    q_desc_o.pos_x  = pos_x_i;
  end

  // Rejected items are dropped on accept; they still wait for queue space.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && draw;

endmodule

/* rtl/setx_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_queue
// Small register FIFO of sprite descriptors between front end and expander.
// ----------------------------------------------------------------------------
module setx_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  setx_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output setx_pkg::desc_t pop_desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  setx_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_desc_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

/* rtl/setx_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setx_back
// Expands one sprite descriptor into tile commands, one per cycle while the
// output is not stalled, row by row, behind a registered output stage.
// ----------------------------------------------------------------------------
module setx_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  setx_pkg::desc_t              q_desc_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [setx_pkg::CoordW-1:0]  tile_code_o,
  output logic [setx_pkg::PalW-1:0]    palette_color_o,
  output logic                         flip_x_o,
  output logic                         flip_y_o,
  output logic [setx_pkg::CoordW-1:0]  tile_x_o,
  output logic [setx_pkg::CoordW-1:0]  tile_y_o,
  output logic                         last_tile_o
);

  localparam int unsigned CW = setx_pkg::CoordW;
  localparam int unsigned IW = setx_pkg::IdxW;

  logic                busy_q, busy_d;
  setx_pkg::desc_t     desc_q;
  logic [IW-1:0]       row_q, row_d;
  logic [IW-1:0]       col_q, col_d;
  logic                out_valid_q, out_valid_d;

  logic [CW-1:0]              tile_code_q;
  logic [setx_pkg::PalW-1:0]  palette_q;
  logic                       flip_x_q, flip_y_q, last_q;
  logic [CW-1:0]              tile_x_q, tile_y_q;

  logic [IW-1:0]  smax, cx, cy;
  logic           fire, last, pop;

  always_comb begin
    smax = setx_pkg::side_max(desc_q.size);
    cx   = desc_q.flip_x ? (col_q ^ smax) : col_q;
    cy   = desc_q.flip_y ? (row_q ^ smax) : row_q;
    last = (row_q == smax) && (col_q == smax);
    fire = busy_q && (!out_valid_q || !out_stall_i);
    pop  = q_valid_i && (!busy_q || (fire && last));

    busy_d = busy_q;
    row_d  = row_q;
    col_d  = col_q;
    if (pop) begin
      busy_d = 1'b1;
      row_d  = '0;
      col_d  = '0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else if (col_q == smax) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      desc_q <= q_desc_i;
    end
    if (fire) begin
      tile_code_q <= {1'b0, desc_q.code} +
                     CW'(setx_pkg::layout_ofs(col_q, row_q));
      palette_q   <= setx_pkg::PalBase | setx_pkg::PalW'(desc_q.color);
      flip_x_q    <= desc_q.flip_x;
      flip_y_q    <= desc_q.flip_y;
      tile_x_q    <= {1'b0, desc_q.pos_x} + CW'({cx, 3'b000});
      tile_y_q    <= {1'b0, desc_q.pos_y} + CW'({cy, 3'b000});
      last_q      <= last;
    end
  end

  assign q_pop_o         = pop;
  assign out_valid_o     = out_valid_q;
  assign tile_code_o     = tile_code_q;
  assign palette_color_o = palette_q;
  assign flip_x_o        = flip_x_q;
  assign flip_y_o        = flip_y_q;
  assign tile_x_o        = tile_x_q;
  assign tile_y_o        = tile_y_q;
  assign last_tile_o     = last_q;

endmodule

/* rtl/sprite_entry_tile_expander.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander
// Expands a five-word sprite entry into 8x8 tile draw commands.
// ----------------------------------------------------------------------------
// The first tile command of a drawn sprite passes the queue, the expander's descriptor register and its output stage.
// The expander emits one command per cycle while the output is not stalled, so a
//   drawn sprite yields 1, 4, 16 or 64 commands; rejected entries never enter the queue.
// The descriptor queue holds QueueDepth sprites ahead of the expander.
// Reset clears the pass priority to 0 and empties queue and output stage.
module sprite_entry_tile_expander #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [setx_pkg::PrioW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [setx_pkg::WordW-1:0]   attr_word_i,
  input  logic [setx_pkg::WordW-1:0]   code_word_i,
  input  logic [setx_pkg::WordW-1:0]   color_word_i,
  input  logic [setx_pkg::WordW-1:0]   pos_y_i,
  input  logic [setx_pkg::WordW-1:0]   pos_x_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [setx_pkg::CoordW-1:0]  tile_code_o,
  output logic [setx_pkg::PalW-1:0]    palette_color_o,
  output logic                         flip_x_o,
  output logic                         flip_y_o,
  output logic [setx_pkg::CoordW-1:0]  tile_x_o,
  output logic [setx_pkg::CoordW-1:0]  tile_y_o,
  output logic                         last_tile_o
);

  logic            q_full, q_push, q_valid, q_pop;
  setx_pkg::desc_t push_desc, pop_desc;

  setx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .attr_word_i  (attr_word_i),
    .code_word_i  (code_word_i),
    .color_word_i (color_word_i),
    .pos_y_i      (pos_y_i),
    .pos_x_i      (pos_x_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_desc_o     (push_desc)
  );

  setx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_desc_o  (pop_desc)
  );

  setx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_desc_i        (pop_desc),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tile_code_o     (tile_code_o),
    .palette_color_o (palette_color_o),
    .flip_x_o        (flip_x_o),
    .flip_y_o        (flip_y_o),
    .tile_x_o        (tile_x_o),
    .tile_y_o        (tile_y_o),
    .last_tile_o     (last_tile_o)
  );

endmodule
